// ===== rtl/slid_pkg.sv =====
// Package for the sorted list store: shared widths, opcode and status codes,
// the control state type and the command struct that drives the cell row.
// No dependencies.
package slid_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int VAL_W       = 32;
    localparam int OP_W        = 2;
    localparam int STAT_W      = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_DUMP   = 2'd2
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE      = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_DUMPED    = 3'd3,
        STAT_EMPTY     = 3'd4
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_DUMP = 1'b1
    } fsm_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        cell_op_t                 op;
        logic signed [VAL_W-1:0]  value;
    } cell_ctrl_t;

endpackage

// ===== rtl/slid_cell.sv =====
// One storage cell of the sorted row: holds one value and its valid bit.
// Depends on slid_pkg for the command struct and value width.
module slid_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  slid_pkg::cell_ctrl_t              ctrl,
    input  logic signed [slid_pkg::VAL_W-1:0] left_val,
    input  logic                              left_vld,
    input  logic                              left_sel,
    input  logic signed [slid_pkg::VAL_W-1:0] right_val,
    input  logic                              right_vld,
    input  logic signed [slid_pkg::VAL_W-1:0] head_val,
    output logic signed [slid_pkg::VAL_W-1:0] val,
    output logic                              vld,
    output logic                              sel,
    output logic                              match
);

    logic signed [slid_pkg::VAL_W-1:0] val_reg;
    logic signed [slid_pkg::VAL_W-1:0] val_next;
    logic                              vld_reg;
    logic                              vld_next;
    logic                              ge;

    // A cell is at or past the insert point when it is empty or holds a
    // larger value; the row is sorted, so this flag rises once along it.
    assign sel   = !vld_reg || (val_reg > ctrl.value);
    assign ge    = vld_reg && (val_reg >= ctrl.value);
    assign match = vld_reg && (val_reg == ctrl.value);
    assign val   = val_reg;
    assign vld   = vld_reg;

    always_comb
    begin
        val_next = val_reg;
        vld_next = vld_reg;
        case (ctrl.op)
            slid_pkg::CELL_INSERT:
            begin
                if (left_sel)
                begin
                    val_next = left_val;
                    vld_next = left_vld;
                end
                else if (sel)
                begin
                    val_next = ctrl.value;
                    vld_next = 1'b1;
                end
            end
            slid_pkg::CELL_DELETE:
            begin
                // Issued only when a match exists; the run of equal values is
                // contiguous, so every cell from the first one not below the
                // value moves down by one.
                if (ge)
                begin
                    val_next = right_val;
                    vld_next = right_vld;
                end
            end
            slid_pkg::CELL_ROTATE:
            begin
                if (vld_reg)
                begin
                    val_next = right_vld ? right_val : head_val;
                end
            end
            default:
            begin
                val_next = val_reg;
                vld_next = vld_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== rtl/sorted_list_insert_delete.sv =====
// Sorted list store, top level: a row of DEPTH cells kept in ascending order.
// Insert, delete and a dump of the empty store load one result word; an unknown opcode loads none.
// A dump of N > 0 entries streams N words, rotating the row, one per cycle unless m_tready is low.
// No input word is accepted while a dump is streaming.
// Reset (rst_n, asynchronous, active low) empties the store and the output register.
module sorted_list_insert_delete #(
    parameter int DEPTH = slid_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: opcode [1:0], value [33:2], zero padding [39:34]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [slid_pkg::IN_TDATA_W-1:0]     s_tdata,
    // m_tdata: status [2:0], entry [34:3], zero padding [39:35]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [slid_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VW    = slid_pkg::VAL_W;
    localparam int SW    = slid_pkg::STAT_W;

    // Input word fields.
    slid_pkg::opcode_t      opcode;
    logic signed [VW-1:0]   in_value;

    assign opcode   = slid_pkg::opcode_t'(s_tdata[slid_pkg::OP_W-1:0]);
    assign in_value = s_tdata[slid_pkg::OP_W +: VW];

    // Control state.
    slid_pkg::fsm_t         state_reg;
    slid_pkg::fsm_t         state_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       dump_cnt_reg;
    logic [CNT_W-1:0]       dump_cnt_next;

    // Output register, which decouples the store from the downstream side.
    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    slid_pkg::status_t      status_reg;
    slid_pkg::status_t      status_next;
    logic signed [VW-1:0]   entry_reg;
    logic signed [VW-1:0]   entry_next;
    logic                   last_reg;
    logic                   last_next;
    logic                   load_out;

    // Cell row wiring.
    slid_pkg::cell_ctrl_t   cell_ctrl;
    logic signed [VW-1:0]   val_w    [DEPTH];
    logic signed [VW-1:0]   lval_w   [DEPTH];
    logic signed [VW-1:0]   rval_w   [DEPTH];
    logic [DEPTH-1:0]       vld_w;
    logic [DEPTH-1:0]       lvld_w;
    logic [DEPTH-1:0]       lsel_w;
    logic [DEPTH-1:0]       rvld_w;
    logic [DEPTH-1:0]       sel_w;
    logic [DEPTH-1:0]       match_w;

    logic                   out_free;
    logic                   full;
    logic                   found;
    logic                   dump_last;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign found     = |match_w;
    // While a dump streams, the dump counter stays below the entry count, so the increment fits CNT_W.
    assign dump_last = (CNT_W'(dump_cnt_reg + 1'b1) == count_reg);

    // Each cell sees its lower neighbor for inserts, its upper neighbor for
    // deletes and rotation, and the head cell, which wraps to the last valid
    // cell during a dump so that the row comes back to its order afterwards.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign lval_w[gi] = '0;
                assign lvld_w[gi] = 1'b0;
                assign lsel_w[gi] = 1'b0;
            end
            else
            begin : g_inner_left
                assign lval_w[gi] = val_w[gi-1];
                assign lvld_w[gi] = vld_w[gi-1];
                assign lsel_w[gi] = sel_w[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign rval_w[gi] = '0;
                assign rvld_w[gi] = 1'b0;
            end
            else
            begin : g_inner_right
                assign rval_w[gi] = val_w[gi+1];
                assign rvld_w[gi] = vld_w[gi+1];
            end

            slid_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .left_val  (lval_w[gi]),
                .left_vld  (lvld_w[gi]),
                .left_sel  (lsel_w[gi]),
                .right_val (rval_w[gi]),
                .right_vld (rvld_w[gi]),
                .head_val  (val_w[0]),
                .val       (val_w[gi]),
                .vld       (vld_w[gi]),
                .sel       (sel_w[gi]),
                .match     (match_w[gi])
            );
        end
    endgenerate

    // Next state: a dump of a non-empty store enters the streaming state and
    // leaves it when the final entry is loaded into the output register.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slid_pkg::FSM_IDLE:
            begin
                if (s_tvalid && out_free && (opcode == slid_pkg::OP_DUMP)
                    && (count_reg != '0))
                begin
                    state_next = slid_pkg::FSM_DUMP;
                end
            end
            slid_pkg::FSM_DUMP:
            begin
                if (out_free && dump_last)
                begin
                    state_next = slid_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = slid_pkg::FSM_IDLE;
            end
        endcase
    end

    // Outputs: handshake, cell command, counters and the result word.
    always_comb
    begin
        s_tready        = 1'b0;
        cell_ctrl.op    = slid_pkg::CELL_HOLD;
        cell_ctrl.value = in_value;
        count_next      = count_reg;
        dump_cnt_next   = dump_cnt_reg;
        load_out        = 1'b0;
        status_next     = slid_pkg::STAT_DONE;
        entry_next      = '0;
        last_next       = 1'b1;
        case (state_reg)
            slid_pkg::FSM_IDLE:
            begin
                s_tready = out_free;
                if (s_tvalid && out_free)
                begin
                    case (opcode)
                        slid_pkg::OP_INSERT:
                        begin
                            load_out = 1'b1;
                            if (full)
                            begin
                                status_next = slid_pkg::STAT_FULL;
                            end
                            else
                            begin
                                cell_ctrl.op = slid_pkg::CELL_INSERT;
                                count_next   = CNT_W'(count_reg + 1'b1);
                            end
                        end
                        slid_pkg::OP_DELETE:
                        begin
                            load_out = 1'b1;
                            if (found)
                            begin
                                cell_ctrl.op = slid_pkg::CELL_DELETE;
                                count_next   = CNT_W'(count_reg - 1'b1);
                            end
                            else
                            begin
                                status_next = slid_pkg::STAT_NOT_FOUND;
                            end
                        end
                        slid_pkg::OP_DUMP:
                        begin
                            dump_cnt_next = '0;
                            if (count_reg == '0)
                            begin
                                load_out    = 1'b1;
                                status_next = slid_pkg::STAT_EMPTY;
                            end
                        end
                        default:
                        begin
                            // The unused opcode is taken and leaves no trace.
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            slid_pkg::FSM_DUMP:
            begin
                if (out_free)
                begin
                    load_out      = 1'b1;
                    status_next   = slid_pkg::STAT_DUMPED;
                    entry_next    = val_w[0];
                    last_next     = dump_last;
                    cell_ctrl.op  = slid_pkg::CELL_ROTATE;
                    dump_cnt_next = CNT_W'(dump_cnt_reg + 1'b1);
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign m_tvalid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= slid_pkg::FSM_IDLE;
            count_reg    <= '0;
            dump_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dump_cnt_reg <= dump_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg <= status_next;
            entry_reg  <= entry_next;
            last_reg   <= last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{(slid_pkg::OUT_TDATA_W - SW - VW){1'b0}}, entry_reg, status_reg};

    // The count never exceeds the number of cells.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    // The valid bits always agree with the entry count.
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(vld_w) == 32'(count_reg))
        else $error("valid cells disagree with entry count");

    // Valid cells form one run starting at the head cell.
    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_w & (vld_w + DEPTH'(1))) == '0)
        else $error("valid cells are not packed at the head");

    // No input word is taken while a dump streams.
    a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == slid_pkg::FSM_DUMP) |-> !s_tready)
        else $error("input accepted during dump");

endmodule
